[sv/ppdf_pkg.sv]
// Shared constants, codes, pointer helpers and control structs for the
// parallel-port DAC FIFO core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppdf_pkg;

    localparam int FIFO_DEPTH = 64;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);
    localparam int CMP_W      = ((LVL_W > 8) ? LVL_W : 8) + 1;

    localparam int IN_W  = 48;
    localparam int OUT_W = 56;
    localparam int LEVEL_OUT_W = 7;

    // Command codes.
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_PEEK    = 2'd2;
    localparam logic [1:0] CMD_CONSUME = 2'd3;

    // Register offsets within one parallel-port base.
    localparam logic [1:0] OFF_DATA    = 2'd0;
    localparam logic [1:0] OFF_STATUS  = 2'd1;
    localparam logic [1:0] OFF_CONTROL = 2'd2;

    localparam logic [15:0] PORT_BASE [3] = '{16'h0378, 16'h0278, 16'h03BC};
    localparam logic [15:0] PORT_SPAN = 16'd2;

    localparam logic [7:0] STATUS_INIT = 8'h07;
    localparam logic [7:0] STATUS_FULL = 8'h40;
    localparam logic [7:0] STATUS_ACK  = 8'h04;
    localparam logic [7:0] STATUS_BUSY = 8'h80;

    localparam int CTRL_LEFT_BIT  = 0;
    localparam int CTRL_RIGHT_BIT = 1;
    localparam int CTRL_MODE_BIT  = 3;

    localparam logic [2:0]       STROBE_MAX   = 3'd6;
    localparam logic [LVL_W-1:0] LEVEL_THRESH = LVL_W'(16);
    localparam logic [7:0]       SILENCE      = 8'd128;
    localparam logic [5:0]       STEREO_TALLY = 6'd33;

    typedef struct packed {
        logic load_in;    // capture the accepted input word
        logic exec;       // perform state updates, issue first peek read
        logic peek_next;  // capture first peek sample, issue second read
        logic finish;     // load the result register
    } ppdf_cmd_t;

    typedef struct packed {
        logic is_peek;
        logic out_free;
    } ppdf_stat_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Wrapping add; one subtract suffices while n does not exceed the depth.
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                  input logic [LVL_W-1:0] n);
        logic [LVL_W:0] sum;
        sum = (LVL_W + 1)'(p) + (LVL_W + 1)'(n);
        if (sum >= (LVL_W + 1)'(FIFO_DEPTH)) begin
            sum = sum - (LVL_W + 1)'(FIFO_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

[sv/ppdf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ppdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/ppdf_ctrl.sv]
// Sequencing state machine for the parallel-port DAC FIFO core.
// Depends on ppdf_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module ppdf_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire ppdf_pkg::ppdf_stat_t stat,
    output ppdf_pkg::ppdf_cmd_t      cmd
);
    import ppdf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_PEEK = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = stat.is_peek ? ST_PEEK : ST_FIN;
            end
            ST_PEEK: begin
                cmd.peek_next = 1'b1;
                state_next    = ST_FIN;
            end
            ST_FIN: begin
                // The next word may enter while this result is loaded.
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    s_tready   = 1'b1;
                    if (s_tvalid) begin
                        cmd.load_in = 1'b1;
                        state_next  = ST_EXEC;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[sv/ppdf_datapath.sv]
// Datapath of the parallel-port DAC FIFO core: port decode, latches, FIFO
// pointers, sample stores and the result register. Depends on ppdf_pkg, ppdf_ram.
`timescale 1ns / 1ps
`default_nettype none

module ppdf_datapath (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic                       cfg_wr_data,
    input  wire logic [ppdf_pkg::IN_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [ppdf_pkg::OUT_W-1:0] m_tdata,
    input  wire ppdf_pkg::ppdf_cmd_t        cmd,
    output ppdf_pkg::ppdf_stat_t            stat
);
    import ppdf_pkg::*;

    // Captured input word.
    logic [1:0]  in_cmd_reg;
    logic [15:0] in_port_reg;
    logic [7:0]  in_value_reg;
    logic [7:0]  in_idx_reg;
    logic [7:0]  in_cnt_reg;

    logic enable_reg;

    logic [7:0]       latched_data_reg,    latched_data_next;
    logic [7:0]       latched_control_reg, latched_control_next;
    logic [2:0]       strobe_reg,          strobe_next;
    logic [PTR_W-1:0] l_rd_reg, l_rd_next, l_wr_reg, l_wr_next;
    logic [PTR_W-1:0] r_rd_reg, r_rd_next, r_wr_reg, r_wr_next;
    logic [LVL_W-1:0] l_fill_reg, l_fill_next, r_fill_reg, r_fill_next;
    logic [5:0]       tally_reg, tally_next;
    logic [7:0]       pd_reg, pd_next;
    logic [7:0]       l_now_reg, r_now_reg;
    logic [OUT_W-1:0] m_data_reg;
    logic             m_valid_reg;

    logic             hit;
    logic [1:0]       off;
    logic [15:0]      diff;
    logic             push_l, push_r;
    logic [7:0]       push_l_data;
    logic [7:0]       fall;
    logic [7:0]       status_byte;
    logic [LVL_W-1:0] drop_l, drop_r;
    logic [PTR_W-1:0] l_raddr, r_raddr;
    logic [7:0]       l_rdata, r_rdata;

    logic [7:0]       ln, lx, rn, rx, pn, px;
    logic             stereo;

    function automatic logic [LVL_W-1:0] now_off(input logic [LVL_W-1:0] fill,
                                                 input logic [7:0] idx);
        if (CMP_W'(fill) > CMP_W'(idx)) begin
            return LVL_W'(idx);
        end else if (fill != '0) begin
            return fill - LVL_W'(1);
        end
        return '0;
    endfunction

    function automatic logic has_next(input logic [LVL_W-1:0] fill,
                                      input logic [7:0] idx);
        return CMP_W'(fill) > (CMP_W'(idx) + CMP_W'(1));
    endfunction

    function automatic logic [LVL_W-1:0] clip(input logic [LVL_W-1:0] fill,
                                              input logic [7:0] cnt);
        return (CMP_W'(cnt) > CMP_W'(fill)) ? fill : LVL_W'(cnt);
    endfunction

    // Port decode against the three bases.
    always_comb begin
        hit  = 1'b0;
        off  = OFF_DATA;
        diff = '0;
        for (int k = 0; k < 3; k++) begin
            if (!hit && in_port_reg >= PORT_BASE[k]
                     && in_port_reg <= PORT_BASE[k] + PORT_SPAN) begin
                hit  = 1'b1;
                diff = in_port_reg - PORT_BASE[k];
                off  = diff[1:0];
            end
        end
    end

    always_comb begin
        status_byte = STATUS_INIT;
        if (strobe_reg >= STROBE_MAX) begin
            if (l_fill_reg >= LEVEL_THRESH) begin
                status_byte = status_byte | STATUS_FULL;
            end else begin
                status_byte = status_byte & ~STATUS_ACK;
            end
        end
        if (!latched_data_reg[7]) begin
            status_byte = status_byte | STATUS_BUSY;
        end
    end

    assign fall = latched_control_reg & ~in_value_reg;

    always_comb begin
        latched_data_next    = latched_data_reg;
        latched_control_next = latched_control_reg;
        strobe_next          = strobe_reg;
        tally_next           = tally_reg;
        pd_next              = pd_reg;
        push_l               = 1'b0;
        push_r               = 1'b0;
        push_l_data          = latched_data_reg;
        drop_l               = '0;
        drop_r               = '0;
        if (cmd.exec) begin
            pd_next = 8'd0;
            case (in_cmd_reg)
                CMD_WRITE: begin
                    pd_next = in_value_reg;
                    if (enable_reg && hit) begin
                        if (off == OFF_DATA) begin
                            latched_data_next = in_value_reg;
                            push_l            = 1'b1;
                            push_l_data       = in_value_reg;
                        end else if (off == OFF_CONTROL) begin
                            push_r = fall[CTRL_RIGHT_BIT];
                            push_l = fall[CTRL_LEFT_BIT];
                            if (fall[CTRL_MODE_BIT] && strobe_reg < STROBE_MAX) begin
                                strobe_next = strobe_reg + 3'd1;
                            end
                            latched_control_next = in_value_reg;
                        end
                    end
                end
                CMD_READ: begin
                    pd_next = in_value_reg;
                    if (enable_reg && hit) begin
                        case (off)
                            OFF_DATA:    pd_next = latched_data_reg;
                            OFF_STATUS:  pd_next = status_byte;
                            OFF_CONTROL: pd_next = latched_control_reg;
                            default:     pd_next = in_value_reg;
                        endcase
                    end
                end
                CMD_CONSUME: begin
                    if (enable_reg) begin
                        drop_l = clip(l_fill_reg, in_cnt_reg);
                        drop_r = clip(r_fill_reg, in_cnt_reg);
                    end
                end
                default: begin
                end
            endcase
        end
        if (push_r && tally_reg < STEREO_TALLY) begin
            tally_next = tally_reg + 6'd1;
        end
    end

    // Pointer and fill updates; a push into a full FIFO drops the oldest entry.
    always_comb begin
        l_rd_next   = ptr_add(l_rd_reg, drop_l);
        l_fill_next = l_fill_reg - drop_l;
        l_wr_next   = l_wr_reg;
        if (push_l) begin
            l_wr_next = ptr_inc(l_wr_reg);
            if (l_fill_reg == LVL_W'(FIFO_DEPTH)) begin
                l_rd_next = ptr_inc(l_rd_reg);
            end else begin
                l_fill_next = l_fill_reg + LVL_W'(1);
            end
        end
        r_rd_next   = ptr_add(r_rd_reg, drop_r);
        r_fill_next = r_fill_reg - drop_r;
        r_wr_next   = r_wr_reg;
        if (push_r) begin
            r_wr_next = ptr_inc(r_wr_reg);
            if (r_fill_reg == LVL_W'(FIFO_DEPTH)) begin
                r_rd_next = ptr_inc(r_rd_reg);
            end else begin
                r_fill_next = r_fill_reg + LVL_W'(1);
            end
        end
    end

    // First read of a peek fetches the current sample, the second the next one.
    // The next address is held afterwards so the sample survives a wait on m_tready.
    assign l_raddr = cmd.exec
                   ? ptr_add(l_rd_reg, now_off(l_fill_reg, in_idx_reg))
                   : ptr_add(l_rd_reg, LVL_W'(CMP_W'(in_idx_reg) + CMP_W'(1)));
    assign r_raddr = cmd.exec
                   ? ptr_add(r_rd_reg, now_off(r_fill_reg, in_idx_reg))
                   : ptr_add(r_rd_reg, LVL_W'(CMP_W'(in_idx_reg) + CMP_W'(1)));

    ppdf_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_left_ram (
        .aclk  (aclk),
        .we    (push_l),
        .waddr (l_wr_reg),
        .wdata (push_l_data),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    ppdf_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_right_ram (
        .aclk  (aclk),
        .we    (push_r),
        .waddr (r_wr_reg),
        .wdata (latched_data_reg),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    assign stereo = tally_reg > 6'd32;

    always_comb begin
        ln = 8'd0;
        lx = 8'd0;
        pn = 8'd0;
        px = 8'd0;
        if (in_cmd_reg == CMD_PEEK) begin
            ln = (l_fill_reg == '0) ? SILENCE : l_now_reg;
            lx = has_next(l_fill_reg, in_idx_reg) ? l_rdata : ln;
            pn = (r_fill_reg == '0) ? SILENCE : r_now_reg;
            px = has_next(r_fill_reg, in_idx_reg) ? r_rdata : pn;
        end
        rn = stereo ? pn : ln;
        rx = stereo ? px : lx;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_cmd_reg   <= s_tdata[1:0];
            in_port_reg  <= s_tdata[17:2];
            in_value_reg <= s_tdata[25:18];
            in_idx_reg   <= s_tdata[33:26];
            in_cnt_reg   <= s_tdata[41:34];
        end
        if (cmd.peek_next) begin
            l_now_reg <= l_rdata;
            r_now_reg <= r_rdata;
        end
        if (cmd.finish) begin
            m_data_reg <= {1'b0, stereo, LEVEL_OUT_W'(r_fill_reg),
                           LEVEL_OUT_W'(l_fill_reg), rx, rn, lx, ln, pd_reg};
        end
        pd_reg <= pd_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg          <= 1'b0;
            latched_data_reg    <= '0;
            latched_control_reg <= '0;
            strobe_reg          <= '0;
            l_rd_reg            <= '0;
            l_wr_reg            <= '0;
            l_fill_reg          <= '0;
            r_rd_reg            <= '0;
            r_wr_reg            <= '0;
            r_fill_reg          <= '0;
            tally_reg           <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                enable_reg <= cfg_wr_data;
            end
            latched_data_reg    <= latched_data_next;
            latched_control_reg <= latched_control_next;
            strobe_reg          <= strobe_next;
            l_rd_reg            <= l_rd_next;
            l_wr_reg            <= l_wr_next;
            l_fill_reg          <= l_fill_next;
            r_rd_reg            <= r_rd_next;
            r_wr_reg            <= r_wr_next;
            r_fill_reg          <= r_fill_next;
            tally_reg           <= tally_next;
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.is_peek  = (in_cmd_reg == CMD_PEEK);
    assign stat.out_free = !m_valid_reg || m_tready;
    assign m_tvalid      = m_valid_reg;
    assign m_tdata       = m_data_reg;

endmodule

`default_nettype wire

[sv/parallel_port_dac_fifo_core.sv]
// Top level of the parallel-port DAC FIFO core.
// Depends on ppdf_pkg, ppdf_ctrl and ppdf_datapath.
`timescale 1ns / 1ps
`default_nettype none

// The core emulates a parallel-port sound DAC at bases 0x378, 0x278 and
// 0x3BC, feeding two 64-entry sample FIFOs. Each input word is one bus
// access, a peek or a consume, and yields exactly one result word. Port
// writes, reads and consumes pass ST_EXEC and ST_FIN; a peek adds ST_PEEK,
// because each FIFO store has one registered read port and the current and
// next samples are fetched one after the other. A new word is taken while
// the previous result is being loaded, and the result register lets the
// result wait on m_tready without blocking the next access from starting.
// The enable register may be written only while no word is in flight.
module parallel_port_dac_fifo_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic                       cfg_wr_data,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // cmd[1:0], port[17:2], value[25:18], sample_index[33:26],
    // consume_count[41:34], zero fill[47:42]
    input  wire logic [ppdf_pkg::IN_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // port_data[7:0], left_now[15:8], left_next[23:16], right_now[31:24],
    // right_next[39:32], left_level[46:40], right_level[53:47],
    // stereo_mode[54], zero fill[55]
    output logic      [ppdf_pkg::OUT_W-1:0] m_tdata
);
    import ppdf_pkg::*;

    ppdf_cmd_t  cmd;
    ppdf_stat_t stat;

    ppdf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ppdf_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for parallel_port_dac_fifo_core: bus accesses, peeks and
// consumes are streamed in and each result word is checked against a behavioral
// predictor kept in a small scoreboard class. Depends on ppdf_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
    import ppdf_pkg::*;

    localparam int LEFT          = 0;
    localparam int RIGHT         = 1;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 10;

    // One input word, cmd in the lowest bits.
    typedef struct packed {
        logic [7:0]  consume_count;
        logic [7:0]  sample_index;
        logic [7:0]  value;
        logic [15:0] port;
        logic [1:0]  cmd;
    } access_t;

    // One result word, port_data in the lowest bits.
    typedef struct packed {
        logic       pad;
        logic       stereo_mode;
        logic [6:0] right_level;
        logic [6:0] left_level;
        logic [7:0] right_next;
        logic [7:0] right_now;
        logic [7:0] left_next;
        logic [7:0] left_now;
        logic [7:0] port_data;
    } result_t;

    class dac_scoreboard;
        bit         enable;
        logic [7:0] latched_data;
        logic [7:0] latched_control;
        int         strobe_edges;
        int         right_tally;
        logic [7:0] sample_mem [2][FIFO_DEPTH];
        int         head [2];
        int         tail [2];
        int         level [2];
        result_t    awaited_results [$];
        int         failures;

        function new();
            enable          = 1'b0;
            latched_data    = '0;
            latched_control = '0;
            strobe_edges    = 0;
            right_tally     = 0;
            failures        = 0;
            for (int ch = 0; ch < 2; ch++) begin
                head[ch]  = 0;
                tail[ch]  = 0;
                level[ch] = 0;
            end
        endfunction

        // A push into a full FIFO discards the oldest sample.
        function void push_sample(int ch, logic [7:0] v);
            if (level[ch] >= FIFO_DEPTH) begin
                head[ch] = (head[ch] + 1) % FIFO_DEPTH;
                level[ch]--;
            end
            sample_mem[ch][tail[ch]] = v;
            tail[ch] = (tail[ch] + 1) % FIFO_DEPTH;
            level[ch]++;
        endfunction

        function void drop_samples(int ch, int n);
            if (n > level[ch]) begin
                n = level[ch];
            end
            head[ch] = (head[ch] + n) % FIFO_DEPTH;
            level[ch] -= n;
        endfunction

        function logic [7:0] stored(int ch, int i);
            return sample_mem[ch][(head[ch] + i) % FIFO_DEPTH];
        endfunction

        function void sample_pair(int ch, int idx, output logic [7:0] now,
                                  output logic [7:0] nxt);
            if (level[ch] > idx) begin
                now = stored(ch, idx);
            end else if (level[ch] > 0) begin
                now = stored(ch, level[ch] - 1);
            end else begin
                now = SILENCE;
            end
            nxt = (level[ch] > idx + 1) ? stored(ch, idx + 1) : now;
        endfunction

        function result_t emulate_access(access_t a);
            result_t    r;
            int         off;
            logic [7:0] prev;
            logic [7:0] status;
            logic [7:0] ln, lx, rn, rx;
            bit         stereo;
            r = '0;
            stereo = (right_tally >= STEREO_TALLY);
            case (a.cmd)
                CMD_WRITE, CMD_READ: begin
                    r.port_data = a.value;
                    off = -1;
                    for (int k = 0; k < 3; k++) begin
                        if (off < 0 && a.port >= PORT_BASE[k] &&
                            a.port <= PORT_BASE[k] + PORT_SPAN) begin
                            off = a.port - PORT_BASE[k];
                        end
                    end
                    if (enable && off >= 0) begin
                        if (a.cmd == CMD_WRITE) begin
                            if (off == OFF_DATA) begin
                                latched_data = a.value;
                                push_sample(LEFT, a.value);
                            end else if (off == OFF_CONTROL) begin
                                prev = latched_control;
                                if (prev[CTRL_RIGHT_BIT] && !a.value[CTRL_RIGHT_BIT]) begin
                                    push_sample(RIGHT, latched_data);
                                    if (right_tally < STEREO_TALLY) begin
                                        right_tally++;
                                    end
                                end
                                if (prev[CTRL_LEFT_BIT] && !a.value[CTRL_LEFT_BIT]) begin
                                    push_sample(LEFT, latched_data);
                                end
                                if (prev[CTRL_MODE_BIT] && !a.value[CTRL_MODE_BIT] &&
                                    strobe_edges < STROBE_MAX) begin
                                    strobe_edges++;
                                end
                                latched_control = a.value;
                            end
                        end else begin
                            if (off == OFF_DATA) begin
                                r.port_data = latched_data;
                            end else if (off == OFF_STATUS) begin
                                status = STATUS_INIT;
                                // Once FIFO mode is detected, the status byte reports
                                // whether the left fill level has reached the threshold.
                                if (strobe_edges >= STROBE_MAX) begin
                                    if (level[LEFT] >= LEVEL_THRESH) begin
                                        status |= STATUS_FULL;
                                    end else begin
                                        status &= ~STATUS_ACK;
                                    end
                                end
                                if (!latched_data[7]) begin
                                    status |= STATUS_BUSY;
                                end
                                r.port_data = status;
                            end else begin
                                r.port_data = latched_control;
                            end
                        end
                    end
                end
                CMD_PEEK: begin
                    sample_pair(LEFT, a.sample_index, ln, lx);
                    if (stereo) begin
                        sample_pair(RIGHT, a.sample_index, rn, rx);
                    end else begin
                        rn = ln;
                        rx = lx;
                    end
                    r.left_now   = ln;
                    r.left_next  = lx;
                    r.right_now  = rn;
                    r.right_next = rx;
                end
                CMD_CONSUME: begin
                    if (enable) begin
                        drop_samples(LEFT, a.consume_count);
                        drop_samples(RIGHT, a.consume_count);
                    end
                end
                default: begin
                end
            endcase
            r.left_level  = 7'(level[LEFT]);
            r.right_level = 7'(level[RIGHT]);
            r.stereo_mode = (right_tally >= STEREO_TALLY);
            return r;
        endfunction

        function void note_access(access_t a);
            awaited_results.push_back(emulate_access(a));
        endfunction

        function string describe(result_t r);
            return $sformatf("pd=%h ln=%h lx=%h rn=%h rx=%h ll=%0d rl=%0d st=%0b",
                             r.port_data, r.left_now, r.left_next, r.right_now,
                             r.right_next, r.left_level, r.right_level, r.stereo_mode);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited_results.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("ERROR: result word with nothing pending: %s", describe(got));
                end
                return;
            end
            want = awaited_results.pop_front();
            if (got.port_data != want.port_data || got.left_now != want.left_now ||
                got.left_next != want.left_next || got.right_now != want.right_now ||
                got.right_next != want.right_next || got.left_level != want.left_level ||
                got.right_level != want.right_level ||
                got.stereo_mode != want.stereo_mode) begin
                failures++;
                if (failures <= 10) begin
                    $display("ERROR: result mismatch at %0t", $realtime);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_wr_en;
    logic                cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;

    dac_scoreboard board;
    bit            quiet = 1'b0;
    int unsigned   stall_left = 0;
    int unsigned   idle_cycles;

    parallel_port_dac_fifo_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #4 aclk = ~aclk;

    // Result side back-pressure in random bursts.
    always @(posedge aclk) begin
        if (stall_left == 0 && !quiet && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 19);
        end
        if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Handshake signals are stable at the falling edge, so a word seen here
    // is the one taken at the next rising edge.
    always @(negedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid && m_tready) begin
            board.check_result(result_t'(m_tdata));
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(negedge aclk);
            if (aresetn !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    function automatic access_t make_access(logic [1:0] cmd, logic [15:0] port,
                                            logic [7:0] value, logic [7:0] idx,
                                            logic [7:0] cnt);
        access_t a;
        a.cmd           = cmd;
        a.port          = port;
        a.value         = value;
        a.sample_index  = idx;
        a.consume_count = cnt;
        return a;
    endfunction

    function automatic logic [15:0] decoded_port(logic [1:0] off);
        return PORT_BASE[$urandom_range(0, 2)] + 16'(off);
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom);
    endfunction

    // Every task here starts and ends just after a rising edge.
    task automatic send_access(input access_t a);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - $bits(access_t)){1'b0}}, a};
        do @(negedge aclk); while (!s_tready);
        board.note_access(a);
        @(posedge aclk);
    endtask

    task automatic set_enable(input bit on);
        s_tvalid <= 1'b0;
        while (board.awaited_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= on;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        board.enable = on;
    endtask

    task automatic run_directed();
        // Emulation off: accesses pass through and consumes do nothing.
        send_access(make_access(CMD_WRITE, 16'h0378, 8'hA5, 8'h00, 8'h00));
        send_access(make_access(CMD_READ, 16'h037A, 8'h5A, 8'hFF, 8'hFF));
        send_access(make_access(CMD_PEEK, 16'hFFFF, 8'hFF, 8'h00, 8'hFF));
        send_access(make_access(CMD_CONSUME, 16'h0378, 8'h00, 8'hFF, 8'hFF));
        set_enable(1'b1);
        // Undecoded ports, including the addresses just outside a window, then decoded ones.
        send_access(make_access(CMD_READ, 16'h0000, 8'h11, 8'h00, 8'h00));
        send_access(make_access(CMD_READ, 16'hFFFF, 8'hEE, 8'hFF, 8'hFF));
        send_access(make_access(CMD_READ, 16'h0377, 8'h33, 8'h00, 8'h00));
        send_access(make_access(CMD_WRITE, 16'h037B, 8'h44, 8'h00, 8'h00));
        send_access(make_access(CMD_WRITE, 16'h0378, 8'hFF, 8'h00, 8'h00));
        send_access(make_access(CMD_WRITE, 16'h0278, 8'h00, 8'h00, 8'h00));
        send_access(make_access(CMD_WRITE, 16'h03BC, 8'h80, 8'h00, 8'h00));
        send_access(make_access(CMD_WRITE, 16'h0279, 8'h55, 8'h00, 8'h00));
        send_access(make_access(CMD_READ, 16'h03BC, 8'h00, 8'h00, 8'h00));
        send_access(make_access(CMD_READ, 16'h0279, 8'h00, 8'h00, 8'h00));
        send_access(make_access(CMD_WRITE, 16'h027A, 8'h0B, 8'h00, 8'h00));
        send_access(make_access(CMD_READ, 16'h037A, 8'h00, 8'h00, 8'h00));
        // All three strobe lines fall at once.
        send_access(make_access(CMD_WRITE, 16'h03BE, 8'h00, 8'h00, 8'h00));
        send_access(make_access(CMD_PEEK, 16'h0000, 8'h00, 8'h00, 8'h00));
        send_access(make_access(CMD_PEEK, 16'h0000, 8'h00, 8'h03, 8'h00));
        send_access(make_access(CMD_PEEK, 16'h0000, 8'h00, 8'hFF, 8'h00));
        send_access(make_access(CMD_CONSUME, 16'h0000, 8'h00, 8'h00, 8'h00));
        send_access(make_access(CMD_CONSUME, 16'h0000, 8'h00, 8'h00, 8'h02));
        send_access(make_access(CMD_CONSUME, 16'h0000, 8'h00, 8'h00, 8'hFF));
        send_access(make_access(CMD_PEEK, 16'h0000, 8'h00, 8'h00, 8'h00));
    endtask

    task automatic run_random(input int unsigned items);
        int unsigned sent;
        int unsigned pick;
        int unsigned burst;
        int          reach;
        logic [2:0]  lines;
        logic [7:0]  mask;
        logic [15:0] port;
        logic [7:0]  idx;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                burst = $urandom_range(1, 12);
                repeat (burst) begin
                    send_access(make_access(CMD_WRITE, decoded_port(OFF_DATA), any_byte(),
                                            any_byte(), any_byte()));
                end
                sent += burst;
            end else if (pick < 42) begin
                // Raise some strobe lines, then drop them to make falling edges.
                lines = 3'($urandom_range(1, 7));
                mask = '0;
                mask[CTRL_LEFT_BIT]  = lines[0];
                mask[CTRL_RIGHT_BIT] = lines[1];
                mask[CTRL_MODE_BIT]  = lines[2];
                send_access(make_access(CMD_WRITE, decoded_port(OFF_CONTROL),
                                        any_byte() | mask, any_byte(), any_byte()));
                send_access(make_access(CMD_WRITE, decoded_port(OFF_CONTROL),
                                        any_byte() & ~mask, any_byte(), any_byte()));
                sent += 2;
            end else if (pick < 52) begin
                send_access(make_access(CMD_READ, decoded_port(2'($urandom_range(0, 2))),
                                        any_byte(), any_byte(), any_byte()));
                sent++;
            end else if (pick < 66) begin
                reach = board.level[LEFT] + 2;
                if (reach > 255) begin
                    reach = 255;
                end
                idx = ($urandom_range(0, 3) == 0) ? any_byte()
                                                  : 8'($urandom_range(0, reach));
                send_access(make_access(CMD_PEEK, 16'($urandom), any_byte(), idx,
                                        any_byte()));
                sent++;
            end else if (pick < 76) begin
                send_access(make_access(CMD_CONSUME, 16'($urandom), any_byte(), any_byte(),
                                        ($urandom_range(0, 3) == 0) ? any_byte()
                                                                    : 8'($urandom_range(0, 6))));
                sent++;
            end else if (pick < 84) begin
                send_access(make_access(CMD_WRITE, decoded_port(2'($urandom_range(0, 2))),
                                        any_byte(), any_byte(), any_byte()));
                sent++;
            end else begin
                // Noise: anything at all, half of it around the decode windows.
                if ($urandom_range(0, 1) == 0) begin
                    port = PORT_BASE[$urandom_range(0, 2)] - 16'd2 + 16'($urandom_range(0, 6));
                end else begin
                    port = 16'($urandom);
                end
                send_access(make_access(2'($urandom), port, any_byte(), any_byte(),
                                        any_byte()));
                sent++;
            end
        end
    endtask

    initial begin
        board = new();
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        run_random(640);
        set_enable(1'b0);
        run_random(120);
        set_enable(1'b1);
        run_random(480);
        quiet = 1'b1;
        run_random(190);

        s_tvalid <= 1'b0;
        while (board.awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.failures == 0 && board.awaited_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/ppdf_pkg.sv
sv/ppdf_ram.sv
sv/ppdf_ctrl.sv
sv/ppdf_datapath.sv
sv/parallel_port_dac_fifo_core.sv
sim/tb_top.sv
